### rtl/core/bts_pkg.sv
package bts_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned VC_W       = 12;  // unscaled vertex coordinate
  localparam int unsigned SCALE_W    = 4;
  localparam int unsigned SV_W       = 16;  // scaled vertex coordinate
  localparam int unsigned DIFF_W     = 17;  // signed coordinate difference
  localparam int unsigned PROD_W     = 2 * DIFF_W;
  localparam int unsigned SUM_W      = PROD_W + 3;
  localparam int unsigned N_W        = 34;  // non-negative weight numerator or denominator
  localparam int unsigned COL_W      = 8;
  localparam int unsigned MUL_W      = N_W + COL_W;
  localparam int unsigned NUM_W      = MUL_W + 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_ONE   = 3'd0,
    REG_VERTEX_TWO   = 3'd1,
    REG_VERTEX_THREE = 3'd2,
    REG_SCALE        = 3'd3,
    REG_COLOUR_ONE   = 3'd4,
    REG_COLOUR_TWO   = 3'd5,
    REG_COLOUR_THREE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] vertex_one;
    logic [CFG_DATA_W-1:0] vertex_two;
    logic [CFG_DATA_W-1:0] vertex_three;
    logic [SCALE_W-1:0]    scale;
    logic [CFG_DATA_W-1:0] colour_one;
    logic [CFG_DATA_W-1:0] colour_two;
    logic [CFG_DATA_W-1:0] colour_three;
  } cfg_t;

  // classified pixel, numerators are zero when outside
  typedef struct packed {
    logic           hit;
    logic [N_W-1:0] n1;
    logic [N_W-1:0] n2;
    logic [N_W-1:0] n3;
    logic [N_W-1:0] den;
  } cls_t;

  function automatic logic [SV_W-1:0] scale_coord(logic [VC_W-1:0] c,
                                                 logic [SCALE_W-1:0] s);
    return SV_W'(c) * SV_W'(s);
  endfunction

endpackage

### rtl/core/bts_pix_if.sv
interface bts_pix_if #(
  parameter int unsigned COORD_BITS = 15
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### rtl/core/bts_res_if.sv
interface bts_res_if;
  logic                      valid;
  logic                      ready;
  logic                      inside_res;
  logic [bts_pkg::COL_W-1:0] red;
  logic [bts_pkg::COL_W-1:0] green;
  logic [bts_pkg::COL_W-1:0] blue;

  modport source (output valid, output inside_res, output red, output green,
                  output blue, input ready);
  modport sink   (input valid, input inside_res, input red, input green,
                  input blue, output ready);
endinterface

### rtl/core/bts_cfg_if.sv
interface bts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bts_pkg::CFG_IDX_W-1:0]  index;
  logic [bts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/bts_queue.sv
module bts_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bts_pkg::cls_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bts_pkg::cls_t head_o
);

  bts_pkg::cls_t                 mem_q [bts_pkg::QUEUE_DEPTH];
  logic [bts_pkg::QPTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [bts_pkg::QPTR_W:0]      cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == (bts_pkg::QPTR_W+1)'(bts_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (bts_pkg::QPTR_W+1)'(bts_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != (bts_pkg::QPTR_W+1)'(bts_pkg::QUEUE_DEPTH))
      |-> (wr_q != rd_q))
    else $error("queue pointers disagree with count");

endmodule

### rtl/core/bts_front.sv
module bts_front #(
  parameter int unsigned COORD_BITS = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bts_pkg::cfg_t cfg_i,
  bts_pix_if.sink       pix_i,
  output bts_pkg::cls_t cls_o,
  output logic          cls_valid_o,
  input  logic          cls_full_i
);

  localparam int unsigned DW = bts_pkg::DIFF_W;
  localparam int unsigned PW = bts_pkg::PROD_W;
  localparam int unsigned SW = bts_pkg::SUM_W;

  logic en;
  logic va_q, vb_q, vc_q, vd_q, ve_q;

  logic [COORD_BITS-1:0] px_q, py_q;
  logic [bts_pkg::SV_W-1:0] x1, y1, x2, y2, x3, y3;
  logic signed [DW-1:0] a_d, b_d, c_d, d_d, e_d, dx_d, dy_d;
  logic signed [DW-1:0] a_q, b_q, c_q, d_q, e_q, dx_q, dy_q;
  logic signed [PW-1:0] pd0_q, pd1_q, p10_q, p11_q, p20_q, p21_q;
  logic signed [SW-1:0] den_q, n1_q, n2_q;
  logic signed [SW-1:0] dn, n1s, n2s, n3s;
  logic                 ins;
  bts_pkg::cls_t        cls_d, cls_q;

  assign en          = !ve_q || !cls_full_i;
  assign pix_i.ready = en;
  assign cls_o       = cls_q;
  assign cls_valid_o = ve_q;

  // scaled vertices and differences
  always_comb begin
    x1 = bts_pkg::scale_coord(cfg_i.vertex_one[11:0], cfg_i.scale);
    y1 = bts_pkg::scale_coord(cfg_i.vertex_one[23:12], cfg_i.scale);
    x2 = bts_pkg::scale_coord(cfg_i.vertex_two[11:0], cfg_i.scale);
    y2 = bts_pkg::scale_coord(cfg_i.vertex_two[23:12], cfg_i.scale);
    x3 = bts_pkg::scale_coord(cfg_i.vertex_three[11:0], cfg_i.scale);
    y3 = bts_pkg::scale_coord(cfg_i.vertex_three[23:12], cfg_i.scale);
    a_d  = $signed(DW'(y2)) - $signed(DW'(y3));
    b_d  = $signed(DW'(x3)) - $signed(DW'(x2));
    c_d  = $signed(DW'(y3)) - $signed(DW'(y1));
    d_d  = $signed(DW'(x1)) - $signed(DW'(x3));
    e_d  = $signed(DW'(y1)) - $signed(DW'(y3));
    dx_d = $signed(DW'(px_q)) - $signed(DW'(x3));
    dy_d = $signed(DW'(py_q)) - $signed(DW'(y3));
  end

  // orient so the denominator is positive, then classify
  always_comb begin
    dn    = den_q[SW-1] ? -den_q : den_q;
    n1s   = den_q[SW-1] ? -n1_q : n1_q;
    n2s   = den_q[SW-1] ? -n2_q : n2_q;
    n3s   = dn - n1s - n2s;
    ins   = (dn != '0) && (n1s > 0) && (n2s > 0) && (n3s > 0);
    cls_d.hit = ins;
    cls_d.n1  = ins ? n1s[bts_pkg::N_W-1:0] : '0;
    cls_d.n2  = ins ? n2s[bts_pkg::N_W-1:0] : '0;
    cls_d.n3  = ins ? n3s[bts_pkg::N_W-1:0] : '0;
    cls_d.den = dn[bts_pkg::N_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en) begin
      va_q <= pix_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= pix_i.pixel_x;
      py_q  <= pix_i.pixel_y;
      a_q   <= a_d;
      b_q   <= b_d;
      c_q   <= c_d;
      d_q   <= d_d;
      e_q   <= e_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      pd0_q <= a_q * d_q;
      pd1_q <= b_q * e_q;
      p10_q <= a_q * dx_q;
      p11_q <= b_q * dy_q;
      p20_q <= c_q * dx_q;
      p21_q <= d_q * dy_q;
      den_q <= SW'(pd0_q) + SW'(pd1_q);
      n1_q  <= SW'(p10_q) + SW'(p11_q);
      n2_q  <= SW'(p20_q) + SW'(p21_q);
      cls_q <= cls_d;
    end
  end

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ve_q && cls_full_i) |=> (ve_q && $stable(cls_q)))
    else $error("classified item lost while queue full");

endmodule

### rtl/core/bts_back.sv
module bts_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bts_pkg::cfg_t cfg_i,
  input  bts_pkg::cls_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  bts_res_if.source     res_o
);

  localparam int unsigned NW  = bts_pkg::NUM_W;
  localparam int unsigned MW  = bts_pkg::MUL_W;
  localparam int unsigned CW  = bts_pkg::COL_W;
  localparam int unsigned NST = CW + 1;  // sum stage plus one stage per quotient bit

  logic en;

  // multiply stage
  logic                  vm_q, im_q;
  logic [bts_pkg::N_W-1:0] dm_q;
  logic [MW-1:0]         m_q [3][3];

  // sum stage (index 0) and divider stages
  logic          v_q   [NST];
  logic          ins_q [NST];
  logic [bts_pkg::N_W-1:0] den_q [NST];
  logic [NW-1:0] rem_q [NST][3];
  logic [CW-1:0] quo_q [NST][3];

  assign en    = !v_q[NST-1] || res_o.ready;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      for (int s = 0; s < NST; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en) begin
      vm_q   <= !empty_i;
      v_q[0] <= vm_q;
      for (int s = 1; s < NST; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    localparam int unsigned HI = 23 - 8 * ch;
    always_ff @(posedge clk_i) begin
      if (en) begin
        m_q[ch][0] <= MW'(head_i.n1) * MW'(cfg_i.colour_one[HI -: 8]);
        m_q[ch][1] <= MW'(head_i.n2) * MW'(cfg_i.colour_two[HI -: 8]);
        m_q[ch][2] <= MW'(head_i.n3) * MW'(cfg_i.colour_three[HI -: 8]);
        rem_q[0][ch] <= NW'(m_q[ch][0]) + NW'(m_q[ch][1]) + NW'(m_q[ch][2]);
        quo_q[0][ch] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      im_q     <= head_i.hit;
      dm_q     <= head_i.den;
      ins_q[0] <= im_q;
      den_q[0] <= dm_q;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 1; j < NST; j++) begin : g_div
    localparam int unsigned SH = NST - 1 - j;
    logic [NW-1:0] dsh;
    assign dsh = NW'(den_q[j-1]) << SH;
    for (genvar ch = 0; ch < 3; ch++) begin : g_dch
      logic ge;
      assign ge = rem_q[j-1][ch] >= dsh;
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[j][ch] <= ge ? rem_q[j-1][ch] - dsh : rem_q[j-1][ch];
          quo_q[j][ch] <= {quo_q[j-1][ch][CW-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        ins_q[j] <= ins_q[j-1];
        den_q[j] <= den_q[j-1];
      end
    end
  end

  assign res_o.valid      = v_q[NST-1];
  assign res_o.inside_res = ins_q[NST-1];
  assign res_o.red        = ins_q[NST-1] ? quo_q[NST-1][0] : '0;
  assign res_o.green      = ins_q[NST-1] ? quo_q[NST-1][1] : '0;
  assign res_o.blue       = ins_q[NST-1] ? quo_q[NST-1][2] : '0;

  a_outside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.inside_res)
      |-> (res_o.red == '0 && res_o.green == '0 && res_o.blue == '0))
    else $error("outside pixel carries colour");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !pop_o)
    else $error("queue popped while result stalled");

  a_inside_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && ins_q[0]) |-> (den_q[0] != '0))
    else $error("inside item with zero denominator");

endmodule

### rtl/core/barycentric_triangle_pixel_shader.sv
// barycentric triangle pixel shader
// configuration: write channel cfg_i, index 0..2 vertices (x 11..0, y 23..12),
//   3 scale factor, 4..6 vertex colours (r 23..16, g 15..8, b 7..0); writes to
//   other indexes are dropped; cfg_i is always ready and must only be written
//   while no pixel is in flight
// input: pix_i carries one pixel coordinate per item
// output: res_o carries inside_res and the interpolated red, green, blue;
//   colours are zero when the pixel is outside, on an edge, or the triangle
//   is degenerate
// throughput: one pixel per cycle while res_o accepts results
// pipeline: an accepted pixel passes the registered edge setup and
//   classification stages, then the queue, then the colour multiply, sum
//   and an 8-stage pipelined divider
// a 4-entry queue separates classification from the colour pipeline; when
//   res_o stalls the colour pipeline holds, the queue fills and then pix_i
//   drops ready; no item is lost
// reset: vertices and colours clear to zero, scale factor to one, all
//   pipelines and the queue empty
module barycentric_triangle_pixel_shader #(
  parameter int unsigned COORD_BITS = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bts_cfg_if.sink   cfg_i,
  bts_pix_if.sink   pix_i,
  bts_res_if.source res_o
);

  bts_pkg::cfg_t cfg_q;
  bts_pkg::cls_t cls, head;
  logic          cls_valid, full, empty, pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{vertex_one:   '0,
                 vertex_two:   '0,
                 vertex_three: '0,
                 scale:        bts_pkg::SCALE_W'(1),
                 colour_one:   '0,
                 colour_two:   '0,
                 colour_three: '0};
    end else if (cfg_i.valid) begin
      case (bts_pkg::cfg_reg_e'(cfg_i.index))
        bts_pkg::REG_VERTEX_ONE:   cfg_q.vertex_one   <= cfg_i.data;
        bts_pkg::REG_VERTEX_TWO:   cfg_q.vertex_two   <= cfg_i.data;
        bts_pkg::REG_VERTEX_THREE: cfg_q.vertex_three <= cfg_i.data;
        bts_pkg::REG_SCALE:
          cfg_q.scale <= cfg_i.data[bts_pkg::SCALE_W-1:0];
        bts_pkg::REG_COLOUR_ONE:   cfg_q.colour_one   <= cfg_i.data;
        bts_pkg::REG_COLOUR_TWO:   cfg_q.colour_two   <= cfg_i.data;
        bts_pkg::REG_COLOUR_THREE: cfg_q.colour_three <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  bts_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_i       (pix_i),
    .cls_o       (cls),
    .cls_valid_o (cls_valid),
    .cls_full_i  (full)
  );

  bts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cls_valid),
    .push_data_i (cls),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  bts_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

### sim/tb_barycentric_triangle_pixel_shader.sv
`timescale 1ns / 1ps

module tb_barycentric_triangle_pixel_shader;

  typedef struct packed {
    logic       inside_res;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } shade_t;

  class shade_board;
    logic [23:0] vtx [3];
    logic [3:0]  scale;
    logic [23:0] col [3];
    shade_t      pending[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned inside_seen;

    function new();
      foreach (vtx[k]) vtx[k] = '0;
      foreach (col[k]) col[k] = '0;
      scale = 4'd1;
      mismatches = 0;
      checked = 0;
      inside_seen = 0;
    endfunction

    function void write_reg(bts_pkg::cfg_reg_e idx, logic [23:0] val);
      case (idx)
        bts_pkg::REG_VERTEX_ONE:   vtx[0] = val;
        bts_pkg::REG_VERTEX_TWO:   vtx[1] = val;
        bts_pkg::REG_VERTEX_THREE: vtx[2] = val;
        bts_pkg::REG_SCALE:        scale = val[3:0];
        bts_pkg::REG_COLOUR_ONE:   col[0] = val;
        bts_pkg::REG_COLOUR_TWO:   col[1] = val;
        bts_pkg::REG_COLOUR_THREE: col[2] = val;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [14:0] px, logic [14:0] py);
      longint x [3];
      longint y [3];
      longint dx, dy, den, n1, n2, n3, num;
      shade_t s;
      for (int k = 0; k < 3; k++) begin
        x[k] = longint'(vtx[k][11:0]) * longint'(scale);
        y[k] = longint'(vtx[k][23:12]) * longint'(scale);
      end
      dx = longint'(px) - x[2];
      dy = longint'(py) - y[2];
      den = (y[1] - y[2]) * (x[0] - x[2]) + (x[2] - x[1]) * (y[0] - y[2]);
      n1 = (y[1] - y[2]) * dx + (x[2] - x[1]) * dy;
      n2 = (y[2] - y[0]) * dx + (x[0] - x[2]) * dy;
      if (den < 0) begin
        den = -den;
        n1 = -n1;
        n2 = -n2;
      end
      n3 = den - n1 - n2;
      s = '0;
      s.inside_res = den != 0 && n1 > 0 && n2 > 0 && n3 > 0;
      if (s.inside_res) begin
        for (int c = 0; c < 3; c++) begin
          num = n1 * longint'(col[0][16-8*c +: 8]) + n2 * longint'(col[1][16-8*c +: 8])
              + n3 * longint'(col[2][16-8*c +: 8]);
          s[16-8*c +: 8] = 8'(num / den);
        end
      end
      pending.push_back(s);
    endfunction

    function void check_shade(shade_t got);
      shade_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no pixel pending: %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.inside_res !== want.inside_res || got.red !== want.red
          || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected in=%0b rgb=%h/%h/%h, got in=%0b rgb=%h/%h/%h",
                   want.inside_res, want.red, want.green, want.blue,
                   got.inside_res, got.red, got.green, got.blue);
      end
      if (got.inside_res === 1'b1) inside_seen++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  bts_cfg_if cfg_bus ();
  bts_pix_if #(.COORD_BITS(15)) pix_bus ();
  bts_res_if res_bus ();

  barycentric_triangle_pixel_shader #(.COORD_BITS(15)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus.sink),
    .pix_i (pix_bus.sink),
    .res_o (res_bus.source)
  );

  shade_board board = new();
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  longint unsigned cycles = 0;
  int unsigned pixels_sent = 0;

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    pix_bus.valid = 1'b0;
    pix_bus.pixel_x = '0;
    pix_bus.pixel_y = '0;
    res_bus.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout");
      $display("tb_barycentric_triangle_pixel_shader failed");
      $finish;
    end
  end

  // result sink with random stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready)
        board.check_shade({res_bus.inside_res, res_bus.red, res_bus.green, res_bus.blue});
      res_bus.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(bts_pkg::cfg_reg_e idx, logic [23:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    board.write_reg(idx, val);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [14:0] px, logic [14:0] py);
    while ($urandom_range(99) < send_idle) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.pixel_x <= px;
    pix_bus.pixel_y <= py;
    do @(posedge clk_i); while (!pix_bus.ready);
    board.note_pixel(px, py);
    pixels_sent++;
  endtask

  task automatic drain();
    pix_bus.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [23:0] pack_vtx(int unsigned x, int unsigned y);
    return {12'(y), 12'(x)};
  endfunction

  // random triangle, mostly small so pixels often land inside
  task automatic load_triangle(logic [3:0] s);
    int unsigned span;
    int unsigned bx, by;
    span = ($urandom_range(3) == 0) ? 4095 : 200;
    bx = $urandom_range(4095 - span);
    by = $urandom_range(4095 - span);
    write_reg(bts_pkg::REG_VERTEX_ONE,
              pack_vtx(bx + $urandom_range(span), by + $urandom_range(span)));
    write_reg(bts_pkg::REG_VERTEX_TWO,
              pack_vtx(bx + $urandom_range(span), by + $urandom_range(span)));
    write_reg(bts_pkg::REG_VERTEX_THREE,
              pack_vtx(bx + $urandom_range(span), by + $urandom_range(span)));
    write_reg(bts_pkg::REG_SCALE, 24'(s));
    write_reg(bts_pkg::REG_COLOUR_ONE, 24'($urandom()));
    write_reg(bts_pkg::REG_COLOUR_TWO, 24'($urandom()));
    write_reg(bts_pkg::REG_COLOUR_THREE, 24'($urandom()));
  endtask

  task automatic random_pixels(int unsigned count);
    int unsigned xs [3];
    int unsigned ys [3];
    int unsigned lx, hx, ly, hy, s;
    s = board.scale;
    for (int k = 0; k < 3; k++) begin
      xs[k] = board.vtx[k][11:0] * s;
      ys[k] = board.vtx[k][23:12] * s;
    end
    lx = xs[0]; hx = xs[0]; ly = ys[0]; hy = ys[0];
    for (int k = 1; k < 3; k++) begin
      if (xs[k] < lx) lx = xs[k];
      if (xs[k] > hx) hx = xs[k];
      if (ys[k] < ly) ly = ys[k];
      if (ys[k] > hy) hy = ys[k];
    end
    if (hx > 32767) hx = 32767;
    if (hy > 32767) hy = 32767;
    if (lx > hx) lx = hx;
    if (ly > hy) ly = hy;
    repeat (count) begin
      if ($urandom_range(9) == 0)
        send_pixel(15'($urandom()), 15'($urandom()));
      else
        send_pixel(15'($urandom_range(hx, lx)), 15'($urandom_range(hy, ly)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: degenerate triangle at the origin
    send_pixel(15'd0, 15'd0);
    send_pixel(15'h7fff, 15'h7fff);
    drain();

    // right triangle with a flat fill, then edge, vertex and interior pixels
    write_reg(bts_pkg::REG_VERTEX_ONE, pack_vtx(0, 0));
    write_reg(bts_pkg::REG_VERTEX_TWO, pack_vtx(100, 0));
    write_reg(bts_pkg::REG_VERTEX_THREE, pack_vtx(0, 100));
    write_reg(bts_pkg::REG_SCALE, 24'd1);
    write_reg(bts_pkg::REG_COLOUR_ONE, 24'h5a3cc1);
    write_reg(bts_pkg::REG_COLOUR_TWO, 24'h5a3cc1);
    write_reg(bts_pkg::REG_COLOUR_THREE, 24'h5a3cc1);
    send_pixel(15'd10, 15'd10);
    send_pixel(15'd0, 15'd50);
    send_pixel(15'd50, 15'd50);
    send_pixel(15'd100, 15'd0);
    send_pixel(15'd1, 15'd1);
    drain();

    // maximal triangle, scale factor 8, extreme colours
    write_reg(bts_pkg::REG_VERTEX_ONE, pack_vtx(4095, 0));
    write_reg(bts_pkg::REG_VERTEX_TWO, pack_vtx(0, 4095));
    write_reg(bts_pkg::REG_VERTEX_THREE, pack_vtx(4095, 4095));
    write_reg(bts_pkg::REG_SCALE, 24'd8);
    write_reg(bts_pkg::REG_COLOUR_ONE, 24'hffffff);
    write_reg(bts_pkg::REG_COLOUR_TWO, 24'h000000);
    write_reg(bts_pkg::REG_COLOUR_THREE, 24'hff00ff);
    send_pixel(15'h7fff, 15'h7fff);
    send_pixel(15'd30000, 15'd30000);
    send_pixel(15'd20000, 15'd32000);
    send_pixel(15'd32760, 15'd100);
    drain();

    // out-of-range scale factors and a collinear triangle
    write_reg(bts_pkg::REG_SCALE, 24'd15);
    send_pixel(15'd32000, 15'd32000);
    send_pixel(15'h5555, 15'h2aaa);
    drain();
    write_reg(bts_pkg::REG_SCALE, 24'd0);
    send_pixel(15'd0, 15'd0);
    send_pixel(15'd5, 15'd5);
    drain();
    write_reg(bts_pkg::REG_VERTEX_ONE, pack_vtx(0, 0));
    write_reg(bts_pkg::REG_VERTEX_TWO, pack_vtx(10, 10));
    write_reg(bts_pkg::REG_VERTEX_THREE, pack_vtx(20, 20));
    write_reg(bts_pkg::REG_SCALE, 24'd1);
    send_pixel(15'd10, 15'd10);
    send_pixel(15'd5, 15'd6);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 33 : (phase == 1) ? 63 : 0;
      recv_idle = (phase == 0) ? 63 : (phase == 1) ? 33 : 0;
      for (int t = 0; t < 4; t++) begin
        load_triangle((t == 0) ? 4'd1 : (t == 1) ? 4'd8 : 4'($urandom_range(8, 1)));
        random_pixels(66);
        drain();
      end
    end

    pix_bus.valid <= 1'b0;
    drain();
    $display("covered %0d pixels over degenerate, flat and random triangles, scales 0..15",
             pixels_sent);
    $display("%0d results checked, %0d inside, %0d mismatches",
             board.checked, board.inside_seen, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("tb_barycentric_triangle_pixel_shader passed");
    else
      $display("tb_barycentric_triangle_pixel_shader failed");
    $finish;
  end

endmodule
